// ----- rtl/pst_pkg.sv -----
`default_nettype none
package pst_pkg;

  localparam int BEAN_SLOTS    = 2;
  localparam int HISTORY_DEPTH = 4;
  localparam int MS_PER_SECOND = 1000;

  localparam int TGT_W      = 7;
  localparam int BEAN_W     = 3;
  localparam int SHOWN_W    = 11;
  localparam int ELAPSED_W  = 20;
  localparam int RELEASE_W  = 16;
  localparam int HOLDOFF_W  = 16;
  localparam int MIN_W      = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int HIST_PORTS = 4;

  localparam int BEAN_IDX_W = (BEAN_SLOTS > 1) ? $clog2(BEAN_SLOTS) : 1;
  localparam int MS_W       = $clog2(MS_PER_SECOND);
  localparam int FRAC_W     = (MS_W > 0) ? MS_W : 1;

  // exact floor division by MS_PER_SECOND for any ELAPSED_W-bit value
  localparam int DIV_SHIFT = ELAPSED_W + MS_W;
  localparam int RECIP_W   = ELAPSED_W + 1;
  localparam int PROD_W    = ELAPSED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(MS_PER_SECOND) - 64'd1) / 64'(MS_PER_SECOND));

  localparam logic [FRAC_W-1:0]    MS_LAST        = FRAC_W'(MS_PER_SECOND - 1);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = {ELAPSED_W{1'b1}};
  localparam logic [RELEASE_W-1:0] RELEASE_MAX    = {RELEASE_W{1'b1}};
  localparam logic [SHOWN_W-1:0]   SHOWN_MAX      = {SHOWN_W{1'b1}};
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET  = 16'd1000;
  localparam logic [MIN_W-1:0]     MIN_SHOT_RESET = 7'd10;
  localparam logic [TGT_W-1:0]     TARGET_RESET   = 7'd30;
  localparam logic [TGT_W-1:0]     TARGET_MAX     = 7'd99;
  localparam logic [TGT_W-1:0]     HIST_CLAMP     = 7'd99;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLDOFF  = 1'b0,
    REG_MIN_SHOT = 1'b1
  } cfg_reg_t;

  typedef logic [TGT_W-1:0] hist_entry_t;

  typedef struct packed {
    logic              push;
    logic [BEAN_W-1:0] sel;
    hist_entry_t       secs;
  } hist_ctl_t;

  typedef struct packed {
    logic [TGT_W-1:0]   target_seconds;
    logic [BEAN_W-1:0]  bean_index;
    logic [SHOWN_W-1:0] shown_seconds;
    logic               counting;
    logic               shot_recorded;
  } status_t;

  typedef struct packed {
    status_t     status;
    hist_entry_t hist_newest;
    hist_entry_t hist_second;
    hist_entry_t hist_third;
    hist_entry_t hist_oldest;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/pst_core.sv -----
`default_nettype none
module pst_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             fire,
  input  wire logic                             pump_on,
  input  wire logic                             up_push,
  input  wire logic                             down_push,
  input  wire logic                             bean_push,
  input  wire logic                             cfg_write,
  input  wire logic [pst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pst_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pst_pkg::status_t                      status,
  output pst_pkg::hist_ctl_t                    hist_ctl
);
  import pst_pkg::*;

  logic [HOLDOFF_W-1:0] release_holdoff_ms;
  logic [MIN_W-1:0]     min_shot_seconds;

  logic [ELAPSED_W-1:0] elapsed_ms, elapsed_ms_next, e1;
  logic [RELEASE_W-1:0] release_ms, release_ms_next, r1;
  logic [FRAC_W-1:0]    frac_ms, frac_ms_next, frac1;
  logic [SHOWN_W-1:0]   whole_secs, whole_secs_next, secs1;
  logic                 is_counting, is_counting_next;
  logic [TGT_W-1:0]     target_time, target_time_next, t1;
  logic [BEAN_W-1:0]    bean_sel, bean_sel_next;
  logic [SHOWN_W-1:0]   shown_secs, shown_secs_next;

  logic [BEAN_W:0]      bean_inc;
  logic                 ending, record;
  logic [ELAPSED_W-1:0] net_ms, quot;
  logic [PROD_W-1:0]    prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      release_holdoff_ms <= HOLDOFF_RESET;
      min_shot_seconds   <= MIN_SHOT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_HOLDOFF:  release_holdoff_ms <= cfg_data[HOLDOFF_W-1:0];
        REG_MIN_SHOT: min_shot_seconds   <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // one millisecond passes
    e1    = (elapsed_ms != ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;
    r1    = (release_ms != RELEASE_MAX) ? release_ms + 1'b1 : release_ms;
    frac1 = frac_ms;
    secs1 = whole_secs;
    // whole seconds of elapsed_ms kept incrementally
    if (elapsed_ms != ELAPSED_MAX) begin
      if (frac_ms == MS_LAST) begin
        frac1 = '0;
        secs1 = (whole_secs == SHOWN_MAX) ? whole_secs : whole_secs + 1'b1;
      end else begin
        frac1 = frac_ms + 1'b1;
      end
    end

    bean_inc      = {1'b0, bean_sel} + 1'b1;
    bean_sel_next = bean_sel;
    if (bean_push) begin
      bean_sel_next = (bean_inc < (BEAN_W+1)'(BEAN_SLOTS)) ? bean_inc[BEAN_W-1:0] : '0;
    end

    t1 = (up_push && target_time < TARGET_MAX) ? target_time + 1'b1 : target_time;
    target_time_next = (down_push && t1 != '0) ? t1 - 1'b1 : t1;

    // shot length with the off time taken out
    net_ms = (e1 > ELAPSED_W'(r1)) ? e1 - ELAPSED_W'(r1) : '0;
    prod   = PROD_W'(net_ms) * PROD_W'(RECIP);
    quot   = ELAPSED_W'(prod >> DIV_SHIFT);

    elapsed_ms_next  = e1;
    release_ms_next  = r1;
    frac_ms_next     = frac1;
    whole_secs_next  = secs1;
    is_counting_next = is_counting;
    ending           = 1'b0;
    if (pump_on) begin
      release_ms_next = '0;
      if (!is_counting) begin
        elapsed_ms_next  = '0;
        frac_ms_next     = '0;
        whole_secs_next  = '0;
        is_counting_next = 1'b1;
      end
    end else if (is_counting && r1 > release_holdoff_ms) begin
      ending           = 1'b1;
      is_counting_next = 1'b0;
    end
    record = ending && (quot >= ELAPSED_W'(min_shot_seconds));

    shown_secs_next = is_counting_next ? whole_secs_next : shown_secs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms  <= '0;
      release_ms  <= '0;
      frac_ms     <= '0;
      whole_secs  <= '0;
      is_counting <= 1'b0;
      target_time <= TARGET_RESET;
      bean_sel    <= '0;
      shown_secs  <= '0;
    end else if (fire) begin
      elapsed_ms  <= elapsed_ms_next;
      release_ms  <= release_ms_next;
      frac_ms     <= frac_ms_next;
      whole_secs  <= whole_secs_next;
      is_counting <= is_counting_next;
      target_time <= target_time_next;
      bean_sel    <= bean_sel_next;
      shown_secs  <= shown_secs_next;
    end
  end

  assign status.target_seconds = target_time_next;
  assign status.bean_index     = bean_sel_next;
  assign status.shown_seconds  = shown_secs_next;
  assign status.counting       = is_counting_next;
  assign status.shot_recorded  = record;

  assign hist_ctl.push = fire && record;
  assign hist_ctl.sel  = bean_sel_next;
  assign hist_ctl.secs = (quot > ELAPSED_W'(HIST_CLAMP)) ? HIST_CLAMP : quot[TGT_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/pst_hist.sv -----
`default_nettype none
module pst_hist (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pst_pkg::hist_ctl_t ctl,
  output pst_pkg::hist_entry_t hist_newest,
  output pst_pkg::hist_entry_t hist_second,
  output pst_pkg::hist_entry_t hist_third,
  output pst_pkg::hist_entry_t hist_oldest
);
  import pst_pkg::*;

  hist_entry_t             rows [BEAN_SLOTS][HISTORY_DEPTH];
  hist_entry_t             row_cur  [HISTORY_DEPTH];
  hist_entry_t             row_next [HISTORY_DEPTH];
  hist_entry_t             tap [HIST_PORTS];
  logic [BEAN_IDX_W-1:0]   idx;

  assign idx = ctl.sel[BEAN_IDX_W-1:0];

  // selected row as it reads after this transfer, newest first
  always_comb begin
    row_cur     = rows[idx];
    row_next[0] = ctl.push ? ctl.secs : row_cur[0];
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      row_next[i] = ctl.push ? row_cur[i-1] : row_cur[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BEAN_SLOTS; b++) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          rows[b][i] <= '0;
        end
      end
    end else if (ctl.push) begin
      rows[idx] <= row_next;
    end
  end

  // positions past the history depth read as empty
  for (genvar k = 0; k < HIST_PORTS; k++) begin : g_tap
    if (k < HISTORY_DEPTH) begin : g_live
      assign tap[k] = row_next[k];
    end else begin : g_empty
      assign tap[k] = '0;
    end
  end

  assign hist_newest = tap[0];
  assign hist_second = tap[1];
  assign hist_third  = tap[2];
  assign hist_oldest = tap[3];

endmodule
`default_nettype wire

// ----- rtl/pst_outbuf.sv -----
`default_nettype none
module pst_outbuf (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire pst_pkg::result_t din,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output pst_pkg::result_t dout
);
  import pst_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign pop      = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        // receiver stalled: park the new result
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      dout <= skid_valid ? skid_data : din;
    end
    if (out_valid && !pop && push) begin
      skid_data <= din;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pump_shot_timer_with_history.sv -----
// Shot timer for a pump switch, fed one item per millisecond tick.
// Input channel (in_valid/in_stall): pump_on level plus one-shot up, down
// and bean-select pushes. Output channel (out_valid/out_stall): target,
// selected bean, shown seconds, counting flag, shot_recorded and the four
// newest history entries of the selected bean.
// Configuration: cfg_write with cfg_index 0 sets the release hold-off in ms,
// index 1 the minimum recorded shot length in seconds; write only while idle.
// The result of an item is registered in the result register, or in the skid
// while that register waits. Throughput: one item per cycle while in_stall is
// low; all state updates are done in the accepting cycle, the path set by the
// one reciprocal multiply that turns the net shot time into seconds.
// A two-entry output buffer (result register plus skid) lets a new item in
// while a result waits; when the receiver stalls, one more item is taken and
// then in_stall rises until the receiver takes the waiting result.
// Reset (rst, synchronous): hold-off 1000 ms, minimum 10 s, target 30 s,
// bean 0, timers and the whole history cleared, output buffer empty.
`default_nettype none
module pump_shot_timer_with_history (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            pump_on,
  input  wire logic                            up_push,
  input  wire logic                            down_push,
  input  wire logic                            bean_push,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [pst_pkg::TGT_W-1:0]            target_seconds,
  output logic [pst_pkg::BEAN_W-1:0]           bean_index,
  output logic [pst_pkg::SHOWN_W-1:0]          shown_seconds,
  output logic                                 counting,
  output logic                                 shot_recorded,
  output logic [pst_pkg::TGT_W-1:0]            hist_newest,
  output logic [pst_pkg::TGT_W-1:0]            hist_second,
  output logic [pst_pkg::TGT_W-1:0]            hist_third,
  output logic [pst_pkg::TGT_W-1:0]            hist_oldest,
  input  wire logic                            cfg_write,
  input  wire logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pst_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pst_pkg::*;

  logic      fire;
  status_t   status;
  hist_ctl_t hist_ctl;
  result_t   result, out_data;

  assign fire = in_valid && !in_stall;

  pst_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .pump_on   (pump_on),
    .up_push   (up_push),
    .down_push (down_push),
    .bean_push (bean_push),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .hist_ctl  (hist_ctl)
  );

  pst_hist u_hist (
    .clk         (clk),
    .rst         (rst),
    .ctl         (hist_ctl),
    .hist_newest (result.hist_newest),
    .hist_second (result.hist_second),
    .hist_third  (result.hist_third),
    .hist_oldest (result.hist_oldest)
  );

  assign result.status = status;

  pst_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .din       (result),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (out_data)
  );

  assign target_seconds = out_data.status.target_seconds;
  assign bean_index     = out_data.status.bean_index;
  assign shown_seconds  = out_data.status.shown_seconds;
  assign counting       = out_data.status.counting;
  assign shot_recorded  = out_data.status.shot_recorded;
  assign hist_newest    = out_data.hist_newest;
  assign hist_second    = out_data.hist_second;
  assign hist_third     = out_data.hist_third;
  assign hist_oldest    = out_data.hist_oldest;

  // backpressure only ever comes with a result already waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending result");

  // after every transfer in, a result is pending on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted item produced no result");

  // a recorded shot has just ended
  a_record_ends_shot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && shot_recorded) |-> !counting)
    else $error("shot recorded while still counting");

  a_bean_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, bean_index} < (BEAN_W+1)'(BEAN_SLOTS)))
    else $error("bean index beyond slot count");

endmodule
`default_nettype wire
